### rtl/rcmr_pkg.sv
// Shared constants and types for the relative-change max-reduce block.
// No dependencies; used by rcmr_div and relative_change_max_reduce.
`timescale 1ns / 1ps
`default_nettype none

package rcmr_pkg;

	localparam int WORD_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	localparam int DIFF_W = 31;
	localparam int TOL_W  = 31;

	// clamp width of the cell difference: min(WORD_WIDTH - 1, DIFF_W)
	localparam int LIM_W = (WORD_WIDTH - 1 < DIFF_W) ? WORD_WIDTH - 1 : DIFF_W;
	// compare width for the divider overflow check
	localparam int CMP_W = (FRAC_BITS + 1 > WORD_WIDTH) ? FRAC_BITS + 1 : WORD_WIDTH;
	// compare width for the tolerance check
	localparam int TCMP_W = (TOL_W > WORD_WIDTH) ? TOL_W : WORD_WIDTH;
	localparam int CNT_W = $clog2(WORD_WIDTH);

	localparam logic [WORD_WIDTH-1:0] ONE_FIX =
		{{(WORD_WIDTH - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	localparam logic [TOL_W-1:0] TOL_RESET = {{(TOL_W - 1){1'b0}}, 1'b1};

	localparam int ADDR_W = 2;
	localparam int DATA_W = 32;
	localparam logic [ADDR_W-1:0] ADDR_TOLERANCE = 2'd0;

	typedef struct packed {
		logic                    done;  // one-cycle pulse, quotient ready
		logic                    ovf;   // zero divisor or quotient above word max
		logic [WORD_WIDTH-2:0]   quo;   // quotient magnitude
	} div_res_t;

endpackage

`default_nettype wire

### rtl/rcmr_div.sv
// Radix-2 restoring divider: (num << FRAC_BITS) / den on magnitudes, one bit a cycle.
// Depends on rcmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcmr_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [rcmr_pkg::WORD_WIDTH-1:0]  num,
	input  wire logic [rcmr_pkg::WORD_WIDTH-1:0]  den,
	output rcmr_pkg::div_res_t                    res
);
	import rcmr_pkg::*;

	localparam int NW = WORD_WIDTH + FRAC_BITS;

	logic                  busy_q;
	logic                  done_q;
	logic                  ovf_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [WORD_WIDTH-1:0] rem_q;
	logic [WORD_WIDTH-1:0] den_q;
	logic [WORD_WIDTH-2:0] sh_q;
	logic [WORD_WIDTH-2:0] quo_q;

	logic [NW-1:0]         n_full;
	logic [FRAC_BITS:0]    r0;
	logic [CMP_W-1:0]      r0_ext;
	logic [CMP_W-1:0]      den_ext;
	logic                  start_ovf;
	logic [WORD_WIDTH:0]   trial;
	logic [WORD_WIDTH:0]   den_t;
	logic [WORD_WIDTH:0]   sub_t;
	logic                  ge;

	// top bits of the dividend: quotient overflows when they already reach den
	assign n_full    = {num, {FRAC_BITS{1'b0}}};
	assign r0        = n_full[NW-1:WORD_WIDTH-1];
	assign r0_ext    = CMP_W'(r0);
	assign den_ext   = CMP_W'(den);
	assign start_ovf = (den == '0) || (r0_ext >= den_ext);

	assign trial = {rem_q, sh_q[WORD_WIDTH-2]};
	assign den_t = {1'b0, den_q};
	assign sub_t = trial - den_t;
	assign ge    = trial >= den_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (start_ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(WORD_WIDTH - 1);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= start_ovf;
			den_q <= den;
			rem_q <= r0_ext[WORD_WIDTH-1:0];
			sh_q  <= n_full[WORD_WIDTH-2:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? sub_t[WORD_WIDTH-1:0] : trial[WORD_WIDTH-1:0];
			sh_q  <= {sh_q[WORD_WIDTH-3:0], 1'b0};
			quo_q <= {quo_q[WORD_WIDTH-3:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.ovf  = ovf_q;
	assign res.quo  = quo_q;

endmodule

`default_nettype wire

### rtl/relative_change_max_reduce.sv
// Top level: relative-change max-reduce over grid cells, with APB tolerance register.
// Depends on rcmr_pkg and rcmr_div.
//
// Usage:
//   Input channel (in_valid/in_stall) takes one cell per transaction: new_value,
//   previous_value (signed Q16.16) and last_cell. Output channel (out_valid/out_stall)
//   returns one transaction per cell: adjusted_previous (previous, or 1.0 when its
//   magnitude is under tolerance), and on the last cell done_res=1 with
//   max_difference = max over the grid of |new/prev - ref|; otherwise both are 0.
//   Each cell passes through the magnitude, tolerance, divider start, divider wait,
//   difference and max steps in that order. The serial divider produces one quotient
//   bit per cycle and dominates the time per cell; when the divisor is zero or the
//   quotient overflows, the divider skips its loop. in_stall is high while a cell is
//   in flight, so the block takes no new cell until the current one is through.
//   A finished result sits in the output register; the next cell may be taken while
//   it waits. If the receiver stalls and the next cell finishes, the block holds it
//   until the output register frees, then loads it.
//   Reset (arst_n low) empties the block, clears the running max and sets tolerance
//   to 1. tolerance is written at byte address 0; reads return it.
`timescale 1ns / 1ps
`default_nettype none

module relative_change_max_reduce (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// APB configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [rcmr_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [rcmr_pkg::DATA_W-1:0]       pwdata,
	output logic      [rcmr_pkg::DATA_W-1:0]       prdata,
	output logic                                   pready,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [rcmr_pkg::WORD_WIDTH-1:0]   new_value,
	input  wire logic [rcmr_pkg::WORD_WIDTH-1:0]   previous_value,
	input  wire logic                              last_cell,
	// output channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [rcmr_pkg::WORD_WIDTH-1:0]   adjusted_previous,
	output logic      [rcmr_pkg::DIFF_W-1:0]       max_difference,
	output logic                                   done_res
);
	import rcmr_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MAG   = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;
	localparam logic [2:0] ST_POST  = 3'd5;
	localparam logic [2:0] ST_MAX   = 3'd6;

	logic [2:0]            state_q;
	logic [TOL_W-1:0]      tol_q;
	logic [DIFF_W-1:0]     run_max_q;
	logic                  out_valid_q;

	// cell payload
	logic [WORD_WIDTH-1:0] new_q;
	logic [WORD_WIDTH-1:0] prev_q;
	logic                  last_q;
	logic [WORD_WIDTH-1:0] num_mag_q;
	logic [WORD_WIDTH-1:0] den_mag_q;
	logic [WORD_WIDTH-1:0] den_adj_q;
	logic [WORD_WIDTH-1:0] adj_prev_q;
	logic                  ref_one_q;
	logic                  neg_q;
	logic [DIFF_W-1:0]     diff_q;

	// output register
	logic [WORD_WIDTH-1:0] out_prev_q;
	logic [DIFF_W-1:0]     out_max_q;
	logic                  out_done_q;

	logic                  cfg_wr;
	logic                  in_acc;
	logic                  out_free;
	logic                  div_start;
	div_res_t              div_res;
	logic [TCMP_W-1:0]     den_cmp;
	logic [TCMP_W-1:0]     tol_cmp;
	logic                  below;
	logic [WORD_WIDTH-1:0] q_ext;
	logic [WORD_WIDTH-1:0] val;
	logic [DIFF_W-1:0]     diff_c;
	logic [DIFF_W-1:0]     new_max;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_TOLERANCE);

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_TOLERANCE) begin
			prdata = DATA_W'(tol_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_wr) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	// ---------------- control ----------------
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign div_start = (state_q == ST_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			run_max_q   <= '0;
		end else begin
			// load a finished cell, else keep a stalled result
			out_valid_q <= ((state_q == ST_MAX) && out_free) || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_MAG;
					end
				end
				ST_MAG:   state_q <= ST_PREP;
				ST_PREP:  state_q <= ST_START;
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_res.done) begin
						state_q <= ST_POST;
					end
				end
				ST_POST:  state_q <= ST_MAX;
				ST_MAX: begin
					if (out_free) begin
						run_max_q   <= last_q ? '0 : new_max;
						state_q     <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- datapath ----------------
	// tolerance check on the previous magnitude
	assign den_cmp = TCMP_W'(den_mag_q);
	assign tol_cmp = TCMP_W'(tol_q);
	assign below   = den_cmp < tol_cmp;

	// |q - ref| with sign of the quotient; negative quotient adds the reference; saturated on overflow
	assign q_ext = {1'b0, div_res.quo};
	always_comb begin
		val = q_ext;
		if (ref_one_q) begin
			if (neg_q) begin
				val = q_ext + ONE_FIX;
			end else if (q_ext >= ONE_FIX) begin
				val = q_ext - ONE_FIX;
			end else begin
				val = ONE_FIX - q_ext;
			end
		end
		if (div_res.ovf || (|val[WORD_WIDTH-1:LIM_W])) begin
			diff_c = DIFF_W'({LIM_W{1'b1}});
		end else begin
			diff_c = DIFF_W'(val[LIM_W-1:0]);
		end
	end

	assign new_max = (diff_q > run_max_q) ? diff_q : run_max_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			new_q  <= new_value;
			prev_q <= previous_value;
			last_q <= last_cell;
		end
		if (state_q == ST_MAG) begin
			num_mag_q <= new_q[WORD_WIDTH-1] ? (~new_q + 1'b1) : new_q;
			den_mag_q <= prev_q[WORD_WIDTH-1] ? (~prev_q + 1'b1) : prev_q;
		end
		if (state_q == ST_PREP) begin
			ref_one_q  <= !below;
			den_adj_q  <= below ? ONE_FIX : den_mag_q;
			adj_prev_q <= below ? ONE_FIX : prev_q;
			neg_q      <= new_q[WORD_WIDTH-1] ^ (prev_q[WORD_WIDTH-1] && !below);
		end
		if (state_q == ST_POST) begin
			diff_q <= diff_c;
		end
		if ((state_q == ST_MAX) && out_free) begin
			out_prev_q <= adj_prev_q;
			out_max_q  <= last_q ? new_max : '0;
			out_done_q <= last_q;
		end
	end

	rcmr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_mag_q),
		.den    (den_adj_q),
		.res    (div_res)
	);

	assign out_valid         = out_valid_q;
	assign adjusted_previous = out_prev_q;
	assign max_difference    = out_max_q;
	assign done_res          = out_done_q;

endmodule

`default_nettype wire

### test/tb_relative_change_max_reduce.sv
// Testbench for relative_change_max_reduce: directed and random grids of cells,
// a self-contained cell-difference predictor, and an in-order result check.
// Depends on rcmr_pkg and the relative_change_max_reduce RTL.
`timescale 1ns / 1ps

module tb_relative_change_max_reduce;

	import rcmr_pkg::*;

	localparam int W = WORD_WIDTH;

	// One output transaction as the block should present it
	typedef struct packed {
		logic [W-1:0]      adjusted;
		logic [DIFF_W-1:0] max_diff;
		logic              done;
	} cell_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [W-1:0]      new_value, previous_value;
	logic              last_cell;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [W-1:0]      adjusted_previous;
	logic [DIFF_W-1:0] max_difference;
	logic              done_res;

	// Predictor state: tolerance register copy and the grid's running maximum
	logic [TOL_W-1:0]  tol_shadow;
	logic [DIFF_W-1:0] grid_max;

	cell_result_t      pending_results[$];
	int                mismatches = 0;
	bit                calm = 1'b0;  // both sides stop idling while set
	int                hold_left = 0;

	relative_change_max_reduce DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.new_value(new_value), .previous_value(previous_value), .last_cell(last_cell),
		.out_valid(out_valid), .out_stall(out_stall),
		.adjusted_previous(adjusted_previous), .max_difference(max_difference),
		.done_res(done_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// Magnitude of a signed word; the most negative word gives 2^(W-1)
	function automatic logic [63:0] word_mag(logic [W-1:0] w);
		return w[W-1] ? (64'd1 << W) - 64'(w) : 64'(w);
	endfunction

	// |new / prev - ref| in fixed point, clamped to the largest difference
	function automatic logic [63:0] cell_gap(logic [W-1:0] nw, logic [W-1:0] pw,
			bit ref_one);
		logic [63:0] lim, word_max, num, den, qmag;
		longint      q, d;
		lim      = 64'h7FFF_FFFF;
		word_max = (64'd1 << (W - 1)) - 1;
		num      = word_mag(nw);
		den      = word_mag(pw);
		if (den == 0)
			return lim;  // zero divisor behaves like overflow
		qmag = (num << FRAC_BITS) / den;
		if (qmag > word_max)
			return lim;
		q = (nw[W-1] ^ pw[W-1]) ? -longint'(qmag) : longint'(qmag);
		d = q - (ref_one ? longint'(64'd1 << FRAC_BITS) : 64'sd0);
		if (d < 0)
			d = -d;
		if (64'(d) > lim)
			return lim;
		return 64'(d);
	endfunction

	// Expected transaction for one cell; updates the running maximum
	function automatic cell_result_t predict_cell(logic [W-1:0] nw, logic [W-1:0] pw,
			bit last);
		cell_result_t r;
		bit           ref_one;
		logic [63:0]  gap;
		ref_one = 1'b1;
		if (word_mag(pw) < 64'(tol_shadow)) begin
			pw      = ONE_FIX;
			ref_one = 1'b0;
		end
		gap = cell_gap(nw, pw, ref_one);
		if (gap > 64'(grid_max))
			grid_max = gap[DIFF_W-1:0];
		r.adjusted = pw;
		if (last) begin
			r.max_diff = grid_max;
			r.done     = 1'b1;
			grid_max   = '0;
		end else begin
			r.max_diff = '0;
			r.done     = 1'b0;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
	endtask

	// Output transactions are compared in order against the oldest prediction
	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(adjusted_previous), 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (adjusted_previous !== want.adjusted)
					report_mismatch("adjusted_previous", 64'(adjusted_previous),
						64'(want.adjusted));
				if (max_difference !== want.max_diff)
					report_mismatch("max_difference", 64'(max_difference),
						64'(want.max_diff));
				if (done_res !== want.done)
					report_mismatch("done_res", 64'(done_res), 64'(want.done));
			end
		end
	end

	// Receiver stalls: short random ones, plus rare long holds that outlast a
	// whole cell so a finished result has to wait behind the output register
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!calm && $urandom_range(9999) < 3) begin
			out_stall <= 1'b1;
			hold_left <= $urandom_range(40, 100);
		end else begin
			out_stall <= !calm && $urandom_range(99) < 4;
		end
	end

	// ---------------------------------------------------------------- drivers

	// One cell transaction; in_valid stays high afterwards so a following cell
	// can go back to back
	task automatic send_cell(logic [W-1:0] nw, logic [W-1:0] pw, bit last);
		if (!calm && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 45)) @(posedge clk);
		end
		new_value      <= nw;
		previous_value <= pw;
		last_cell      <= last;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_cell(nw, pw, last));
	endtask

	// Stop sending and wait for every predicted result to come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// APB write of the tolerance register, then a read back of it
	task automatic write_tolerance(logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_TOLERANCE;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tol_shadow = value[TOL_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		want = DATA_W'(tol_shadow);
		if (prdata !== want)
			report_mismatch("tolerance read back", 64'(prdata), 64'(want));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic logic [W-1:0] pick_extreme();
		case ($urandom_range(8))
			0: return '0;
			1: return W'(1);
			2: return '1;
			3: return {1'b0, {(W - 1){1'b1}}};
			4: return {1'b1, {(W - 1){1'b0}}};
			5: return ONE_FIX;
			6: return -ONE_FIX;
			7: return W'(tol_shadow);
			default: return W'(tol_shadow) - 1;
		endcase
	endfunction

	// With the reset tolerance: a zero previous value, unit divisors, equal operands, quotient
	// overflow, opposite signs, the most negative word, out-of-range difference
	task automatic test_reset_tolerance();
		send_cell('0, '0, 1'b0);                           // below tolerance -> 1.0
		send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);     // ratio 1.0
		send_cell(32'h8000_0000, 32'h8000_0000, 1'b1);     // most negative both sides
		send_cell(32'h8000_0000, 32'h0000_0001, 1'b1);     // quotient overflow
		send_cell(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_cell(32'h0000_0001, 32'h7FFF_FFFF, 1'b0);
		send_cell(-ONE_FIX, ONE_FIX, 1'b0);                // ratio -1
		send_cell(32'h0003_0000, ONE_FIX, 1'b1);
		send_cell(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);     // ratio just above -1
		send_cell(32'h8000_0001, ONE_FIX, 1'b1);           // difference saturates
		send_cell(ONE_FIX, 32'hFFFF_FFFF, 1'b0);           // magnitude 1 kept
		send_cell(32'h0001_8000, 32'h0001_0001, 1'b1);
		drain_results();
	endtask

	// Tolerance zero keeps a zero previous value: divide by zero
	task automatic test_zero_tolerance();
		write_tolerance('0);
		send_cell(ONE_FIX, '0, 1'b1);
		send_cell('0, '0, 1'b0);
		send_cell(32'h1234_5678, 32'h0000_0001, 1'b1);
		drain_results();
	endtask

	// Largest tolerance: every previous value with magnitude under 2^31 - 1 is replaced
	task automatic test_full_tolerance();
		write_tolerance('1);
		send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_cell(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_cell(32'h8000_0000, 32'h8000_0001, 1'b0);
		send_cell(32'hDEAD_BEEF, 32'h0000_0000, 1'b1);
		drain_results();
	endtask

	// Grids of random length; most cells look like a converging iterate, the rest
	// sit near the tolerance, are fully random, or are extremes
	task automatic test_random_grids(logic [DATA_W-1:0] tol_value, int n_cells, bit quiet);
		int           sent, len, i, mode;
		logic [W-1:0] nw, pw;
		bit           last;
		write_tolerance(tol_value);
		calm = quiet;
		sent = 0;
		while (sent < n_cells) begin
			len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
			for (i = 0; i < len && sent < n_cells; i++) begin
				mode = $urandom_range(99);
				if (mode < 60) begin
					pw = W'($urandom() >> $urandom_range(1, 28));
					if ($urandom_range(1))
						pw = -pw;
					nw = pw + ($signed(pw) >>> $urandom_range(3, 24)) + $urandom_range(0, 6) - 3;
				end else if (mode < 75) begin
					pw = W'(tol_shadow) + $urandom_range(0, 4) - 2;
					if ($urandom_range(1))
						pw = -pw;
					nw = $urandom();
				end else if (mode < 90) begin
					pw = $urandom();
					nw = $urandom();
				end else begin
					pw = pick_extreme();
					nw = $urandom_range(1) ? pick_extreme() : W'($urandom());
				end
				last = (i == len - 1);
				if ($urandom_range(99) < 5)
					last = 1'($urandom_range(1));  // stray grid boundaries
				send_cell(nw, pw, last);
				sent++;
			end
		end
		drain_results();
		calm = 1'b0;
	endtask

	initial begin
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		in_valid       <= 1'b0;
		new_value      <= '0;
		previous_value <= '0;
		last_cell      <= 1'b0;
		tol_shadow     = TOL_RESET;
		grid_max       = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_tolerance();
		test_zero_tolerance();
		test_full_tolerance();
		test_random_grids(DATA_W'($urandom_range(0, 1 << 17)), 200, 1'b0);
		test_random_grids(DATA_W'(TOL_RESET), 200, 1'b1);
		test_random_grids('0, 150, 1'b0);
		test_random_grids('1, 150, 1'b0);
		test_random_grids($urandom(), 150, 1'b0);
		test_random_grids(DATA_W'(ONE_FIX), 250, 1'b0);

		// let anything stray come out before the verdict
		repeat (45) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### filelist.f
rtl/rcmr_pkg.sv
rtl/rcmr_div.sv
rtl/relative_change_max_reduce.sv
test/tb_relative_change_max_reduce.sv
